// ===== sv/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - shared definitions
// Field widths, operation and status codes, controller state type and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Default sizing of the store
    localparam int SSP_MAX_SUBSTACKS = 8;
    localparam int SSP_MAX_DEPTH     = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int CAP_W    = 5;

    // Capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TOP  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_STACK = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } ssp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the accepted transaction
        logic exec;    // run the operation against the store
        logic load;    // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } ctrl_sts_t;

endpackage

// ===== sv/ssp_if.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface ssp_cmd_if;
    import ssp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] push_value;
    logic [INDEX_W-1:0]        stack_index;

    modport source (output valid, output func, output push_value, output stack_index,
                    input ready);
    modport sink   (input valid, input func, input push_value, input stack_index,
                    output ready);
endinterface

interface ssp_rsp_if;
    import ssp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        substack_count;
    logic                      is_empty;

    modport source (output valid, output read_value, output status,
                    output substack_count, output is_empty, input ready);
    modport sink   (input valid, input read_value, input status,
                    input substack_count, input is_empty, output ready);
endinterface

// ===== sv/ssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - controller
// Sequences one transaction: accept, execute against the store, load result.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssp_pkg::ctrl_sts_t sts,
    output ssp_pkg::ctrl_cmd_t cmd
);
    import ssp_pkg::*;

    ssp_state_t state_reg;
    ssp_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.latch = 1'b0;
        cmd.exec  = 1'b0;
        cmd.load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A captured transaction is executed in the very next cycle
    a_latch_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> cmd.exec)
        else $error("captured transaction was not executed");

    // Execution always hands over to the result load
    a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_LOAD)
        else $error("execute did not advance to load");

    // A blocked result stays pending
    a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && !sts.out_free) |=> state_reg == ST_LOAD)
        else $error("result dropped while output register busy");

endmodule

// ===== sv/ssp_datapath.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - datapath
// Value memory, per-slot fill counts, logical-to-physical slot order,
// live count, capacity register and the output register.
// ----------------------------------------------------------------------------
module ssp_datapath #(
    parameter int MAX_SUBSTACKS = ssp_pkg::SSP_MAX_SUBSTACKS,
    parameter int MAX_DEPTH     = ssp_pkg::SSP_MAX_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ssp_pkg::ctrl_cmd_t                 cmd,
    output ssp_pkg::ctrl_sts_t                 sts,
    input  logic                               cfg_we,
    input  logic [ssp_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic [ssp_pkg::FUNC_W-1:0]         func,
    input  logic signed [ssp_pkg::VALUE_W-1:0] push_value,
    input  logic [ssp_pkg::INDEX_W-1:0]        stack_index,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [ssp_pkg::VALUE_W-1:0] read_value,
    output logic [ssp_pkg::STATUS_W-1:0]       status,
    output logic [ssp_pkg::COUNT_W-1:0]        substack_count,
    output logic                               is_empty
);
    import ssp_pkg::*;

    localparam int SLOT_W    = $clog2(MAX_SUBSTACKS);
    localparam int LIVE_W    = $clog2(MAX_SUBSTACKS + 1);
    localparam int FILL_W    = $clog2(MAX_DEPTH + 1);
    localparam int POS_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int MEM_DEPTH = MAX_SUBSTACKS * (2 ** POS_W);
    localparam int CMP_W     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int IDX_W     = (LIVE_W > INDEX_W) ? LIVE_W : INDEX_W;

    // Captured transaction
    logic [FUNC_W-1:0]         func_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [INDEX_W-1:0]        index_reg;

    // Configuration
    logic [CAP_W-1:0] cap_reg;

    // Store bookkeeping
    logic [SLOT_W-1:0] order_reg  [MAX_SUBSTACKS];
    logic [SLOT_W-1:0] order_next [MAX_SUBSTACKS];
    logic [FILL_W-1:0] fill_reg   [MAX_SUBSTACKS];
    logic [FILL_W-1:0] fill_next  [MAX_SUBSTACKS];
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;

    // Pending result
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                rd_flag_reg;
    logic                rd_flag_next;

    // Value memory
    logic [VALUE_W-1:0] mem [MEM_DEPTH];
    logic [VALUE_W-1:0] mem_rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;

    // Output register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_empty_reg;

    // Operation decode
    logic              is_push;
    logic              is_sel;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;
    logic [IDX_W-1:0]  idx_ext;
    logic [IDX_W-1:0]  live_ext;
    logic [SLOT_W-1:0] ord_sel;
    logic [SLOT_W-1:0] ord_rd;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] fill_sel;
    logic [FILL_W-1:0] fill_rd;
    logic              need_new;
    logic              store_full;
    logic              idx_bad;
    logic              last_plate;

    // Decode the operation and look up slot and fill
    always_comb
    begin
        is_push  = (func_reg == FUNC_PUSH);
        is_sel   = (func_reg == FUNC_POP) || (func_reg == FUNC_TOP);
        cap_ext  = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_DEPTH))
        begin
            eff_cap = CMP_W'(MAX_DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        idx_ext  = IDX_W'(index_reg);
        live_ext = IDX_W'(live_reg);
        // push looks at the first free slot, pop and top at the chosen index
        ord_sel  = is_push ? SLOT_W'(live_reg) : SLOT_W'(idx_ext);
        if ({1'b0, ord_sel} < (SLOT_W + 1)'(MAX_SUBSTACKS))
        begin
            ord_rd = order_reg[ord_sel];
        end
        else
        begin
            ord_rd = '0;
        end
        head       = order_reg[0];
        fill_sel   = is_push ? head : ord_rd;
        fill_rd    = fill_reg[fill_sel];
        need_new   = (live_reg == '0) || (CMP_W'(fill_rd) >= eff_cap);
        store_full = need_new && (live_reg == LIVE_W'(MAX_SUBSTACKS));
        idx_bad    = (idx_ext >= live_ext) || (fill_rd == '0);
        last_plate = (fill_rd == FILL_W'(1));
    end

    // Execute: update order, fills and live count, issue the memory access
    always_comb
    begin
        order_next   = order_reg;
        fill_next    = fill_reg;
        live_next    = live_reg;
        status_next  = status_reg;
        rd_flag_next = rd_flag_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = '0;
        if (cmd.exec)
        begin
            status_next  = STAT_OK;
            rd_flag_next = 1'b0;
            if (is_push)
            begin
                if (store_full)
                begin
                    status_next = STAT_FULL;
                end
                else if (need_new)
                begin
                    // open a fresh sub-stack at the front
                    order_next[0] = ord_rd;
                    for (int i = 1; i < MAX_SUBSTACKS; i++)
                    begin
                        if (LIVE_W'(i) <= live_reg)
                        begin
                            order_next[i] = order_reg[i-1];
                        end
                    end
                    fill_next[ord_rd] = FILL_W'(1);
                    live_next         = live_reg + LIVE_W'(1);
                    mem_we            = 1'b1;
                    mem_addr          = {ord_rd, POS_W'(0)};
                end
                else
                begin
                    fill_next[head] = fill_rd + FILL_W'(1);
                    mem_we          = 1'b1;
                    mem_addr        = {head, POS_W'(fill_rd)};
                end
            end
            else if (is_sel)
            begin
                if (idx_bad)
                begin
                    status_next = STAT_NO_STACK;
                end
                else
                begin
                    rd_flag_next = 1'b1;
                    mem_re       = 1'b1;
                    mem_addr     = {ord_rd, POS_W'(fill_rd - FILL_W'(1))};
                    if (func_reg == FUNC_POP)
                    begin
                        fill_next[ord_rd] = fill_rd - FILL_W'(1);
                        if (last_plate)
                        begin
                            // close the gap and park the emptied slot at the end
                            for (int i = 0; i < MAX_SUBSTACKS - 1; i++)
                            begin
                                if ((IDX_W'(i) >= idx_ext) && (IDX_W'(i + 1) < live_ext))
                                begin
                                    order_next[i] = order_reg[i+1];
                                end
                            end
                            for (int i = 0; i < MAX_SUBSTACKS; i++)
                            begin
                                if (IDX_W'(i + 1) == live_ext)
                                begin
                                    order_next[i] = ord_rd;
                                end
                            end
                            live_next = live_reg - LIVE_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Hold captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= func;
            value_reg <= push_value;
            index_reg <= stack_index;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Bookkeeping and pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SUBSTACKS; i++)
            begin
                order_reg[i] <= SLOT_W'(i);
                fill_reg[i]  <= '0;
            end
            live_reg    <= '0;
            status_reg  <= STAT_OK;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            order_reg   <= order_next;
            fill_reg    <= fill_next;
            live_reg    <= live_next;
            status_reg  <= status_next;
            rd_flag_reg <= rd_flag_next;
        end
    end

    // Value memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_value_reg  <= rd_flag_reg ? mem_rdata_reg : '0;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(live_reg);
            out_empty_reg  <= (live_reg == '0);
        end
    end

    assign sts.out_free   = !out_valid_reg || rsp_ready;
    assign rsp_valid      = out_valid_reg;
    assign read_value     = out_value_reg;
    assign status         = out_status_reg;
    assign substack_count = out_count_reg;
    assign is_empty       = out_empty_reg;

    // Live count never exceeds the number of physical slots
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(MAX_SUBSTACKS))
        else $error("live sub-stack count out of range");

    // A dropped push leaves the store untouched
    a_full_keeps_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status_next == STAT_FULL) |=> $stable(live_reg))
        else $error("dropped push changed the live count");

    // A result appears only after a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load))
        else $error("output valid without a result load");

endmodule

// ===== sv/segmented_stack_of_plates.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - top level
// Bounded sub-stacks of 64-bit values with push, pop-at-index and
// top-at-index over valid/ready channels.
// ----------------------------------------------------------------------------
// Each transaction is accepted, then executed (a single access on the one-port
// value memory plus the slot order and fill count update), then loaded into the
// output register; the load waits while the output register is still full.
// A finished result waits in the output register and the next transaction is
// accepted while it waits. No clearing pass is needed after reset: only
// filled positions are ever read. The user must write the capacity register
// only while no transaction is in flight; the block does not enforce this.
module segmented_stack_of_plates #(
    parameter int MAX_SUBSTACKS = ssp_pkg::SSP_MAX_SUBSTACKS,
    parameter int MAX_DEPTH     = ssp_pkg::SSP_MAX_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ssp_pkg::CAP_W-1:0] cfg_wdata,
    ssp_cmd_if.sink                   cmd,
    ssp_rsp_if.source                 rsp
);
    import ssp_pkg::*;

    ctrl_cmd_t ctl_cmd;
    ctrl_sts_t ctl_sts;

    // Sequence transactions
    ssp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    // Store and result path
    ssp_datapath #(
        .MAX_SUBSTACKS (MAX_SUBSTACKS),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .sts            (ctl_sts),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .func           (cmd.func),
        .push_value     (cmd.push_value),
        .stack_index    (cmd.stack_index),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .read_value     (rsp.read_value),
        .status         (rsp.status),
        .substack_count (rsp.substack_count),
        .is_empty       (rsp.is_empty)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Segmented stack of plates - testbench
// Sends push, pop-at-index, top-at-index and unused operations over the
// command channel and checks every response against an in-bench predictor
// of the sub-stack store. Changes the sub-stack capacity between phases.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
    import ssp_pkg::*;

    // Unused operation code, accepted and answered with no effect
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 115;
    localparam int STEADY_PHASE = 4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        substack_count;
        logic                      is_empty;
    } plate_result_t;

    // Predicts the store and keeps the responses still owed by the block
    class plate_stack_tracker;
        logic [VALUE_W-1:0] plate_mem [SSP_MAX_SUBSTACKS][SSP_MAX_DEPTH];
        bit [CAP_W-1:0]     fill [SSP_MAX_SUBSTACKS];
        bit [INDEX_W-1:0]   order [SSP_MAX_SUBSTACKS];
        int unsigned        live;
        bit [CAP_W-1:0]     capacity;
        plate_result_t      expected_results [$];
        int                 errors;

        function new();
            for (int i = 0; i < SSP_MAX_SUBSTACKS; i++)
            begin
                fill[i]  = '0;
                order[i] = INDEX_W'(i);
            end
            live     = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        // Apply one operation to the store and return the response it yields
        function plate_result_t apply_command(logic [FUNC_W-1:0] func,
                                              logic [VALUE_W-1:0] value,
                                              logic [INDEX_W-1:0] idx);
            plate_result_t    r;
            int unsigned      limit;
            int unsigned      f;
            bit [INDEX_W-1:0] s;
            bit [INDEX_W-1:0] freed;
            r = '0;
            r.status = STAT_OK;
            case (func)
                FUNC_PUSH:
                begin
                    limit = (capacity == 0) ? 1 :
                            ((capacity > SSP_MAX_DEPTH) ? SSP_MAX_DEPTH : capacity);
                    // Open a new sub-stack when there is none or the newest is full
                    if (live == 0 || fill[order[0]] >= limit)
                    begin
                        if (live >= SSP_MAX_SUBSTACKS)
                            r.status = STAT_FULL;
                        else
                        begin
                            freed = order[live];
                            for (int i = live; i > 0; i--)
                                order[i] = order[i-1];
                            order[0] = freed;
                            fill[freed] = '0;
                            live++;
                        end
                    end
                    if (r.status == STAT_OK)
                    begin
                        s = order[0];
                        if (fill[s] < SSP_MAX_DEPTH)
                        begin
                            plate_mem[s][fill[s]] = value;
                            fill[s]++;
                        end
                    end
                end
                FUNC_POP, FUNC_TOP:
                begin
                    if (idx >= live)
                        r.status = STAT_NO_STACK;
                    else
                    begin
                        s = order[idx];
                        f = 32'(fill[s]);
                        if (f == 0)
                            r.status = STAT_NO_STACK;
                        else
                        begin
                            r.read_value = plate_mem[s][f-1];
                            if (func == FUNC_POP)
                            begin
                                fill[s] = CAP_W'(f - 1);
                                // Remove an emptied sub-stack and shift the older ones down
                                if (f == 1)
                                begin
                                    for (int i = idx; i + 1 < live; i++)
                                        order[i] = order[i+1];
                                    order[live-1] = s;
                                    live--;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.substack_count = live[COUNT_W-1:0];
            r.is_empty       = (live == 0);
            return r;
        endfunction

        function void note_command(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                                   logic [INDEX_W-1:0] idx);
            expected_results.push_back(apply_command(func, value, idx));
        endfunction

        function void check_result(plate_result_t got);
            plate_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("response with no command outstanding: value %0d status %0d",
                       got.read_value, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.substack_count !== want.substack_count)
            begin
                $error("substack_count: expected %0d, got %0d",
                       want.substack_count, got.substack_count);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    bit steady;

    ssp_cmd_if cmd_ch();
    ssp_rsp_if rsp_ch();

    plate_stack_tracker tracker;

    segmented_stack_of_plates i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(20 * 400000);
        $display("TB_ERROR");
        $finish;
    end

    // Stall the response side at random (a 20% chance each clock), except in the steady phase
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = rst_n && (steady || $urandom_range(0, 99) >= 20);
        end
    end

    // Record accepted commands and check accepted responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.note_command(cmd_ch.func, cmd_ch.push_value, cmd_ch.stack_index);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result({rsp_ch.read_value, rsp_ch.status,
                                      rsp_ch.substack_count, rsp_ch.is_empty});
        end
    end

    // Drive one transaction, idling at random before it, and wait for its acceptance
    task automatic send_item(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                             logic [INDEX_W-1:0] idx);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       = 1'b1;
        cmd_ch.func        = func;
        cmd_ch.push_value  = value;
        cmd_ch.stack_index = idx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Hold off the command side until every response is back
    task automatic settle();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        tracker.capacity = value;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(VALUE_W-1){1'b1}}};
            1:       return {1'b1, {(VALUE_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random traffic in fill, drain and mixed stretches of 25 transactions
    task automatic run_phase(int n_items);
        int push_pct;
        int pop_pct;
        int top_pct;
        int roll;
        logic [FUNC_W-1:0] func;
        logic [INDEX_W-1:0] idx;
        push_pct = 45;
        pop_pct  = 28;
        top_pct  = 24;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 25 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       begin push_pct = 75; pop_pct = 12; top_pct = 10; end
                    1:       begin push_pct = 25; pop_pct = 55; top_pct = 17; end
                    default: begin push_pct = 45; pop_pct = 28; top_pct = 24; end
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                func = FUNC_PUSH;
            else if (roll < push_pct + pop_pct)
                func = FUNC_POP;
            else if (roll < push_pct + pop_pct + top_pct)
                func = FUNC_TOP;
            else
                func = FUNC_NONE;
            // Aim most indexes at live sub-stacks
            if (tracker.live > 0 && $urandom_range(0, 99) < 80)
                idx = INDEX_W'($urandom_range(0, tracker.live - 1));
            else
                idx = INDEX_W'($urandom_range(0, 7));
            send_item(func, pick_value(), idx);
        end
    endtask

    initial
    begin
        int caps [PHASE_COUNT];
        caps = '{0, 31, 2, 5, 16, 17, 1, 7, 3, 12};
        tracker            = new();
        steady             = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.func        = FUNC_PUSH;
        cmd_ch.push_value  = '0;
        cmd_ch.stack_index = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty store, unused operation, extreme values
        send_item(FUNC_TOP, '0, 3'd0);
        send_item(FUNC_POP, '0, 3'd7);
        send_item(FUNC_NONE, '1, 3'd7);
        send_item(FUNC_PUSH, {1'b0, {(VALUE_W-1){1'b1}}}, 3'd0);
        send_item(FUNC_PUSH, {1'b1, {(VALUE_W-1){1'b0}}}, 3'd0);
        send_item(FUNC_PUSH, '0, 3'd0);
        send_item(FUNC_PUSH, '1, 3'd0);
        send_item(FUNC_TOP, '0, 3'd0);
        send_item(FUNC_POP, '0, 3'd0);
        send_item(FUNC_TOP, '0, 3'd1);

        // Lower the capacity below the newest fill, then fill every slot and overflow
        settle();
        write_capacity(5'd1);
        for (int i = 0; i < 8; i++)
            send_item(FUNC_PUSH, {$urandom, $urandom}, 3'd0);
        send_item(FUNC_POP, '0, 3'd7);
        send_item(FUNC_POP, '0, 3'd3);
        send_item(FUNC_TOP, '0, 3'd7);
        send_item(FUNC_POP, '0, 3'd0);
        send_item(FUNC_PUSH, {$urandom, $urandom}, 3'd0);

        // Random phases, each at its own capacity
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            write_capacity(CAP_W'(caps[p]));
            steady = (p == STEADY_PHASE);
            run_phase(PHASE_ITEMS);
        end
        steady = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ssp_pkg.sv
sv/ssp_if.sv
sv/ssp_ctrl.sv
sv/ssp_datapath.sv
sv/segmented_stack_of_plates.sv
verif/tb.sv
